[rtl/core/cxf_pkg.sv]
`timescale 1ns / 1ps

package cxf_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int KERNEL_SIDE_DEF = 3;

	localparam int CH_W = 8;
	localparam int PX_W = 3 * CH_W;
	localparam int TAPS = 9;
	localparam int TAP_W = 4;
	// |sum| <= 9*255*128 + 510 < 2^19
	localparam int SUM_W = 20;
	localparam int MAG_W = SUM_W - 1;
	localparam int CFG_W = 24;
	localparam int IMG_W = 11;

	localparam logic [2:0] REG_KTOP = 3'd0;
	localparam logic [2:0] REG_KMID = 3'd1;
	localparam logic [2:0] REG_KBOT = 3'd2;
	localparam logic [2:0] REG_SCALE = 3'd3;
	localparam logic [2:0] REG_FILT = 3'd4;
	localparam logic [2:0] REG_WIDTH = 3'd5;

	localparam logic OP_PUSH = 1'b0;

	typedef logic [PX_W-1:0] pixel_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_MAC,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic filter_on;
	} mac_ctl_t;

endpackage

[rtl/core/cxf_line_mem.sv]
`timescale 1ns / 1ps

module cxf_line_mem #(
	parameter int DEPTH = cxf_pkg::MAX_WIDTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  cxf_pkg::pixel_t     wdata,
	input  logic [ADDR_W-1:0]   raddr,
	output cxf_pkg::pixel_t     rdata
);

	cxf_pkg::pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/cxf_mac.sv]
`timescale 1ns / 1ps

// One window tap per cycle: weighted sums per channel plus darkest/brightest tracking.
module cxf_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cxf_pkg::mac_ctl_t               ctl,
	input  cxf_pkg::pixel_t                 window [cxf_pkg::TAPS],
	input  logic [cxf_pkg::TAPS*8-1:0]      weights,
	output logic                            done,
	output cxf_pkg::sum_t                   sums [3]
);

	logic [cxf_pkg::TAP_W-1:0] tap_q;
	logic run_q, fix_q, done_q;
	logic filt_q;
	cxf_pkg::sum_t acc_q [3];
	logic [9:0] lo_i_q, hi_i_q;
	cxf_pkg::pixel_t lo_px_q, hi_px_q;

	cxf_pkg::pixel_t px;
	logic signed [7:0] wt;
	logic [9:0] inten;
	logic signed [16:0] prod [3];

	always_comb begin
		px = window[tap_q];
		wt = signed'(weights[8*tap_q +: 8]);
		inten = 10'(px[7:0]) + 10'(px[15:8]) + 10'(px[23:16]);
		for (int k = 0; k < 3; k++) begin
			prod[k] = $signed({1'b0, px[8*k +: 8]}) * wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fix_q <= 1'b0;
			done_q <= 1'b0;
			tap_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				tap_q <= '0;
			end else if (run_q) begin
				if (tap_q == cxf_pkg::TAP_W'(cxf_pkg::TAPS - 1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end else begin
					tap_q <= tap_q + 1'b1;
				end
			end else if (fix_q) begin
				fix_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			filt_q <= ctl.filter_on;
			for (int k = 0; k < 3; k++) acc_q[k] <= '0;
		end else if (run_q) begin
			for (int k = 0; k < 3; k++) acc_q[k] <= acc_q[k] + cxf_pkg::SUM_W'(prod[k]);
			// ties: darkest keeps the first, brightest takes the last
			if (tap_q == '0 || inten < lo_i_q) begin
				lo_i_q <= inten;
				lo_px_q <= px;
			end
			if (tap_q == '0 || inten >= hi_i_q) begin
				hi_i_q <= inten;
				hi_px_q <= px;
			end
		end else if (fix_q && filt_q) begin
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= acc_q[k] - cxf_pkg::SUM_W'({1'b0, lo_px_q[8*k +: 8]})
					- cxf_pkg::SUM_W'({1'b0, hi_px_q[8*k +: 8]});
			end
		end
	end

	assign done = done_q;
	assign sums = acc_q;

endmodule

[rtl/core/cxf_div.sv]
`timescale 1ns / 1ps

// Restoring division, one quotient bit per cycle, three channels side by side.
// Negative sums clamp to zero, so only nonnegative magnitudes are divided.
module cxf_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cxf_pkg::sum_t       sums [3],
	input  logic [7:0]          divisor,
	output logic                done,
	output cxf_pkg::pixel_t     result
);

	localparam int STEP_W = $clog2(cxf_pkg::MAG_W + 1);

	logic busy_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [7:0] dv_q;
	logic [cxf_pkg::MAG_W-1:0] quo_q [3];
	logic [8:0] rem_q [3];

	logic [8:0] rem_sh [3];
	logic ge [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rem_sh[k] = {rem_q[k][7:0], quo_q[k][cxf_pkg::MAG_W-1]};
			ge[k] = rem_sh[k] >= {1'b0, dv_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(cxf_pkg::MAG_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv_q <= divisor;
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= '0;
				quo_q[k] <= sums[k][cxf_pkg::SUM_W-1] ? '0 : sums[k][cxf_pkg::MAG_W-1:0];
			end
		end else if (busy_q) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= ge[k] ? rem_sh[k] - {1'b0, dv_q} : rem_sh[k];
				quo_q[k] <= {quo_q[k][cxf_pkg::MAG_W-2:0], ge[k]};
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			result[8*k +: 8] = (quo_q[k] > cxf_pkg::MAG_W'(255)) ? 8'hFF : quo_q[k][7:0];
		end
	end

	assign done = done_q;

endmodule

[rtl/core/conv3x3_rgb_extreme_filter.sv]
`timescale 1ns / 1ps
// Border, edge and flush results pass from the request through the line store update to the
// output register; interior pixels also pass through the window multiply-accumulate (one tap
// a cycle, then the extreme correction) and the divider (one bit a cycle).
// One request at a time: in_ready is high only in the idle state.
// Reset: asynchronous, active low; then a clearing pass writes zero to every address of both
// line stores while in_ready stays low. Registers take their reset values at once.
module conv3x3_rgb_extreme_filter #(
	parameter int MAX_WIDTH = cxf_pkg::MAX_WIDTH_DEF,
	parameter int KERNEL_SIDE = cxf_pkg::KERNEL_SIDE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [cxf_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [7:0]                  in_red,
	input  logic [7:0]                  in_green,
	input  logic [7:0]                  in_blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_red,
	output logic [7:0]                  out_green,
	output logic [7:0]                  out_blue,
	output logic                        last_of_frame
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_WIDTH + 2);
	localparam int CW = (ROW_W > cxf_pkg::IMG_W) ? ROW_W : cxf_pkg::IMG_W;
	localparam int NWIN = KERNEL_SIDE * KERNEL_SIDE;

	logic [23:0] ktop_q, kmid_q, kbot_q;
	logic [7:0] scale_q;
	logic filt_q;
	logic [cxf_pkg::IMG_W-1:0] width_q;

	cxf_pkg::state_t state_q, nstate;
	logic [COL_W-1:0] clr_q, col_q;
	logic [ROW_W-1:0] row_q;
	cxf_pkg::pixel_t win_q [NWIN];
	cxf_pkg::pixel_t px_s1;
	cxf_pkg::pixel_t res_q, out_px_q;
	logic last_q, out_last_q, out_valid_q;

	logic [ROW_W-1:0] w_eff;
	logic drain, wrap, no_emit, interior, load_out;
	logic mem_we;
	logic [COL_W-1:0] mem_waddr;
	cxf_pkg::pixel_t up_wdata, lo_wdata, up_rd, lo_rd;
	cxf_pkg::mac_ctl_t mac_ctl;
	logic mac_done, div_start, div_done;
	cxf_pkg::sum_t sums [3];
	cxf_pkg::pixel_t div_res;
	logic [7:0] div_eff;

	always_comb begin
		if (CW'(width_q) < CW'(3)) w_eff = ROW_W'(3);
		else if (CW'(width_q) > CW'(MAX_WIDTH)) w_eff = ROW_W'(MAX_WIDTH);
		else w_eff = ROW_W'(width_q);
		div_eff = (scale_q == 8'd0) ? 8'd1 : scale_q;
		drain = {1'b0, row_q} >= ({1'b0, w_eff} + 1'b1);
		wrap = ((ROW_W + 1)'(col_q) + 1'b1) >= {1'b0, w_eff};
		no_emit = (row_q == '0) || (row_q == ROW_W'(1) && col_q == '0);
		interior = (row_q >= ROW_W'(2)) && ({1'b0, row_q} + 1'b1 <= {1'b0, w_eff})
			&& (col_q >= COL_W'(2))
			&& ((ROW_W + 1)'(col_q) + 1'b1 <= {1'b0, w_eff});
	end

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ktop_q <= 24'h010101;
			kmid_q <= 24'h010101;
			kbot_q <= 24'h010101;
			scale_q <= 8'd9;
			filt_q <= 1'b0;
			width_q <= cxf_pkg::IMG_W'(512);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cxf_pkg::REG_KTOP: ktop_q <= cfg_data;
				cxf_pkg::REG_KMID: kmid_q <= cfg_data;
				cxf_pkg::REG_KBOT: kbot_q <= cfg_data;
				cxf_pkg::REG_SCALE: scale_q <= cfg_data[7:0];
				cxf_pkg::REG_FILT: filt_q <= cfg_data[0];
				cxf_pkg::REG_WIDTH: width_q <= cfg_data[cxf_pkg::IMG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nstate = state_q;
		in_ready = 1'b0;
		mem_we = 1'b0;
		mem_waddr = col_q;
		up_wdata = lo_rd;
		lo_wdata = px_s1;
		mac_ctl.start = 1'b0;
		mac_ctl.filter_on = filt_q;
		div_start = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			cxf_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				up_wdata = '0;
				lo_wdata = '0;
				if (clr_q == COL_W'(MAX_WIDTH - 1)) nstate = cxf_pkg::ST_IDLE;
			end
			cxf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) nstate = cxf_pkg::ST_UPD;
			end
			cxf_pkg::ST_UPD: begin
				mem_we = 1'b1;
				priority if (drain) nstate = cxf_pkg::ST_EMIT;
				else if (no_emit) nstate = cxf_pkg::ST_IDLE;
				else if (interior && col_q != '0) begin
					mac_ctl.start = 1'b1;
					nstate = cxf_pkg::ST_MAC;
				end else nstate = cxf_pkg::ST_EMIT;
			end
			cxf_pkg::ST_MAC: begin
				if (mac_done) begin
					div_start = 1'b1;
					nstate = cxf_pkg::ST_DIV;
				end
			end
			cxf_pkg::ST_DIV: begin
				if (div_done) nstate = cxf_pkg::ST_EMIT;
			end
			cxf_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					nstate = cxf_pkg::ST_IDLE;
				end
			end
			default: nstate = cxf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cxf_pkg::ST_CLEAR;
			clr_q <= '0;
			row_q <= '0;
			col_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NWIN; i++) win_q[i] <= '0;
		end else begin
			state_q <= nstate;
			if (state_q == cxf_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == cxf_pkg::ST_UPD) begin
				for (int i = 0; i < KERNEL_SIDE; i++) begin
					win_q[i*KERNEL_SIDE] <= win_q[i*KERNEL_SIDE + 1];
					win_q[i*KERNEL_SIDE + 1] <= win_q[i*KERNEL_SIDE + 2];
				end
				win_q[2] <= up_rd;
				win_q[5] <= lo_rd;
				win_q[8] <= px_s1;
				if (drain) begin
					row_q <= '0;
					col_q <= '0;
				end else if (wrap) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1 <= (opcode == cxf_pkg::OP_PUSH && row_q < w_eff)
				? {in_blue, in_green, in_red} : '0;
		end
		if (state_q == cxf_pkg::ST_UPD) begin
			// border, edge and drain results all show the old window center-right
			res_q <= win_q[5];
			last_q <= drain;
		end
		if (state_q == cxf_pkg::ST_DIV && div_done) res_q <= div_res;
		if (load_out) begin
			out_px_q <= res_q;
			out_last_q <= last_q;
		end
	end

	cxf_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) u_upper (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (up_wdata),
		.raddr (col_q),
		.rdata (up_rd)
	);

	cxf_line_mem #(.DEPTH(MAX_WIDTH), .ADDR_W(COL_W)) u_lower (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (lo_wdata),
		.raddr (col_q),
		.rdata (lo_rd)
	);

	cxf_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.window  (win_q),
		.weights ({kbot_q, kmid_q, ktop_q}),
		.done    (mac_done),
		.sums    (sums)
	);

	cxf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sums    (sums),
		.divisor (div_eff),
		.done    (div_done),
		.result  (div_res)
	);

	assign out_valid = out_valid_q;
	assign out_red = out_px_q[7:0];
	assign out_green = out_px_q[15:8];
	assign out_blue = out_px_q[23:16];
	assign last_of_frame = out_last_q;

	a_accept_upd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == cxf_pkg::ST_UPD)
		else $error("accepted request not followed by line store update");

	a_drain_home: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cxf_pkg::ST_UPD && drain |=> row_q == '0 && col_q == '0)
		else $error("frame end did not return position to origin");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == cxf_pkg::ST_DIV)
		else $error("divider finished outside its state");

	a_mac_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == cxf_pkg::ST_MAC)
		else $error("window sum finished outside its state");

endmodule
